// ===== rtl/core/eke_pkg.sv =====
// shared types, constants and key tables for the environment key/value extractor
// no dependencies; imported by eke_parser and env_key_value_extractor
package eke_pkg;

   localparam int NAME_LIMIT_DEFAULT = 64;
   localparam int PATH_LIMIT_DEFAULT = 1024;

   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 10;
   localparam int LEVEL_W = 4;
   localparam int CODE_W  = 2;
   localparam int KEY_POS_W = 9;

   localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_EQUALS = 8'h3D;
   localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;

   // mode codes as seen on the result beat
   localparam logic [CODE_W-1:0] CODE_NAME   = 2'd0;
   localparam logic [CODE_W-1:0] CODE_IGNORE = 2'd1;
   localparam logic [CODE_W-1:0] CODE_PATH   = 2'd2;
   localparam logic [CODE_W-1:0] CODE_LEVEL  = 2'd3;

   typedef enum logic [3:0] {
      MODE_NAME   = 4'b0001,
      MODE_IGNORE = 4'b0010,
      MODE_PATH   = 4'b0100,
      MODE_LEVEL  = 4'b1000
   } mode_type;

   typedef struct packed {
      logic                 write_enable;
      logic [INDEX_W-1:0]   write_index;
      logic [BYTE_W-1:0]    write_byte;
      logic [LEVEL_W-1:0]   level_now;
      logic [CODE_W-1:0]    mode_now;
   } result_type;

   localparam int PATH_KEY_LEN  = 22;
   localparam int LEVEL_KEY_LEN = 21;

   localparam logic [BYTE_W-1:0] PATH_KEY [PATH_KEY_LEN] = '{
      8'h52, 8'h45, 8'h50, 8'h4C, 8'h49, 8'h54, 8'h5F, 8'h4C, 8'h44, 8'h5F, 8'h4C,
      8'h49, 8'h42, 8'h52, 8'h41, 8'h52, 8'h59, 8'h5F, 8'h50, 8'h41, 8'h54, 8'h48
   };

   localparam logic [BYTE_W-1:0] LEVEL_KEY [LEVEL_KEY_LEN] = '{
      8'h52, 8'h45, 8'h50, 8'h4C, 8'h49, 8'h54, 8'h5F, 8'h52, 8'h54, 8'h4C, 8'h44,
      8'h5F, 8'h4C, 8'h4F, 8'h47, 8'h5F, 8'h4C, 8'h45, 8'h56, 8'h45, 8'h4C
   };

   // key bytes padded with nul past the end
   function automatic logic [BYTE_W-1:0] path_key_byte(input logic [KEY_POS_W-1:0] pos);
      logic [BYTE_W-1:0] b;
      b = CHAR_NUL;
      if (pos < KEY_POS_W'(PATH_KEY_LEN)) begin
         b = PATH_KEY[pos[4:0]];
      end
      return b;
   endfunction

   function automatic logic [BYTE_W-1:0] level_key_byte(input logic [KEY_POS_W-1:0] pos);
      logic [BYTE_W-1:0] b;
      b = CHAR_NUL;
      if (pos < KEY_POS_W'(LEVEL_KEY_LEN)) begin
         b = LEVEL_KEY[pos[4:0]];
      end
      return b;
   endfunction

   function automatic logic [CODE_W-1:0] mode_code(input mode_type m);
      logic [CODE_W-1:0] c;
      case (m)
         MODE_NAME: begin
            c = CODE_NAME;
         end
         MODE_IGNORE: begin
            c = CODE_IGNORE;
         end
         MODE_PATH: begin
            c = CODE_PATH;
         end
         MODE_LEVEL: begin
            c = CODE_LEVEL;
         end
         default: begin
            c = CODE_NAME;
         end
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/core/eke_parser.sv =====
// per-byte parse step: mode, name match flags, path position and log level
// depends on eke_pkg for key tables, mode type and result struct
module eke_parser
   import eke_pkg::*;
#(
   parameter int NAME_LIMIT = NAME_LIMIT_DEFAULT,
   parameter int PATH_LIMIT = PATH_LIMIT_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [BYTE_W-1:0]   in_byte,
   output result_type          result
);

   localparam int NW = $clog2(NAME_LIMIT + 1);
   localparam int PW = $clog2(PATH_LIMIT);
   localparam int XW = (PW > INDEX_W) ? PW : INDEX_W;
   localparam logic [NW-1:0] NAME_END  = NW'(NAME_LIMIT);
   localparam logic [PW-1:0] PATH_LAST = PW'(PATH_LIMIT - 1);

   mode_type           mode_ff, mode_in;
   logic [NW-1:0]      name_pos_ff, name_pos_in;
   logic               path_match_ff, path_match_in;
   logic               level_match_ff, level_match_in;
   logic [PW-1:0]      path_pos_ff, path_pos_in;
   logic [LEVEL_W-1:0] level_ff, level_in;

   logic               we;
   logic [PW-1:0]      widx;
   logic [BYTE_W-1:0]  wbyte;
   logic [XW-1:0]      widx_ext;

   always_comb begin
      mode_in        = mode_ff;
      name_pos_in    = name_pos_ff;
      path_match_in  = path_match_ff;
      level_match_in = level_match_ff;
      path_pos_in    = path_pos_ff;
      level_in       = level_ff;
      we             = 1'b0;
      widx           = '0;
      wbyte          = CHAR_NUL;
      case (mode_ff)
         MODE_NAME: begin
            if (in_byte == CHAR_EQUALS) begin
               if (path_match_ff) begin
                  mode_in     = MODE_PATH;
                  path_pos_in = '0;
               end else if (level_match_ff) begin
                  mode_in = MODE_LEVEL;
               end else begin
                  mode_in = MODE_IGNORE;
               end
            end else if (name_pos_ff < NAME_END) begin
               // bytes past the limit are dropped
               if (in_byte != path_key_byte(KEY_POS_W'(name_pos_ff))) begin
                  path_match_in = 1'b0;
               end
               if (in_byte != level_key_byte(KEY_POS_W'(name_pos_ff))) begin
                  level_match_in = 1'b0;
               end
               name_pos_in = name_pos_ff + 1'b1;
            end
         end
         MODE_IGNORE: begin
            if (in_byte == CHAR_NUL) begin
               mode_in        = MODE_NAME;
               name_pos_in    = '0;
               path_match_in  = 1'b1;
               level_match_in = 1'b1;
            end
         end
         MODE_PATH: begin
            we = 1'b1;
            if (path_pos_ff >= PATH_LAST) begin
               // store full: terminate at the last slot, drop the rest
               widx    = PATH_LAST;
               mode_in = MODE_IGNORE;
            end else if (in_byte == CHAR_NUL) begin
               widx           = path_pos_ff;
               mode_in        = MODE_NAME;
               name_pos_in    = '0;
               path_match_in  = 1'b1;
               level_match_in = 1'b1;
            end else begin
               widx        = path_pos_ff;
               wbyte       = in_byte;
               path_pos_in = path_pos_ff + 1'b1;
            end
         end
         MODE_LEVEL: begin
            if (in_byte >= CHAR_ZERO && in_byte <= CHAR_NINE) begin
               level_in = LEVEL_W'(in_byte - CHAR_ZERO);
            end
            mode_in = MODE_IGNORE;
         end
         default: begin
            mode_in = MODE_NAME;
         end
      endcase
   end

   assign widx_ext = XW'(widx);

   always_comb begin
      result.write_enable = we;
      result.write_index  = widx_ext[INDEX_W-1:0];
      result.write_byte   = wbyte;
      result.level_now    = level_in;
      result.mode_now     = mode_code(mode_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_NAME;
         name_pos_ff    <= '0;
         path_match_ff  <= 1'b1;
         level_match_ff <= 1'b1;
         path_pos_ff    <= '0;
         level_ff       <= '0;
      end else if (step) begin
         mode_ff        <= mode_in;
         name_pos_ff    <= name_pos_in;
         path_match_ff  <= path_match_in;
         level_match_ff <= level_match_in;
         path_pos_ff    <= path_pos_in;
         level_ff       <= level_in;
      end
   end

endmodule

// ===== rtl/core/env_key_value_extractor.sv =====
// Environment block key/value extractor, top level.
// Depends on eke_pkg and eke_parser.
//
// req_* takes one byte of a NUL-separated NAME=VALUE block per beat. Every
// accepted byte gives exactly one beat on rsp_*: an optional write to the
// external path store (enable, index, byte), the current log level and the
// parse mode after that byte (0 name, 1 ignore, 2 path, 3 level).
//
// After the req accept, a byte passes one input register, the parse step and
// then the result register before rsp_tvalid rises; a stall on rsp_tready can
// hold it in the input register. Throughput is one byte per cycle while
// rsp_tready does not stall.
// A stall on rsp_tready holds the result register; the input register still
// takes one more byte, and req_tready drops only while both hold a beat.
// Synchronous reset empties both registers and returns the parser to name
// mode with both key matches set, path position 0 and level 0.
module env_key_value_extractor
   import eke_pkg::*;
#(
   parameter int NAME_LIMIT = NAME_LIMIT_DEFAULT,
   parameter int PATH_LIMIT = PATH_LIMIT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // write_enable, write_index[10], write_byte[8], level_now[4], mode_now[2], zero pad
   output logic [31:0] rsp_tdata
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        out_data_ff;
   result_type        result;
   logic              advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = req_tvalid || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   eke_parser #(
      .NAME_LIMIT (NAME_LIMIT),
      .PATH_LIMIT (PATH_LIMIT)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (in_byte_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_data_ff.mode_now, out_data_ff.level_now,
                        out_data_ff.write_byte, out_data_ff.write_index,
                        out_data_ff.write_enable};

endmodule
